/* design/lbsd_pkg.sv */
package lbsd_pkg;

    // Default sizes
    localparam int NUM_INDICATORS_DEF = 24;
    localparam int SHIFT_LENGTH_DEF   = 24;

    // Field widths
    localparam int ACTION_W    = 3;
    localparam int INDICATOR_W = 5;
    localparam int RATIO_W     = 11;
    localparam int COUNT_W     = 10;
    localparam int PRODUCT_W   = COUNT_W + RATIO_W;

    // Counter and ratio limits
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 10'd1023;
    localparam logic [COUNT_W-1:0] FULL_SCALE_RESET = 10'd500;
    localparam logic [RATIO_W-1:0] RATIO_ONE        = 11'd1024;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_EVAL    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SET     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REFRESH = 3'd4;

    // Address width of a store with the given number of entries
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* design/lbsd_ram.sv */
module lbsd_ram #(
    parameter int WIDTH = lbsd_pkg::COUNT_W,
    parameter int DEPTH = lbsd_pkg::NUM_INDICATORS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [lbsd_pkg::addr_w(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [lbsd_pkg::addr_w(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lbsd_shift_out.sv */
module lbsd_shift_out #(
    parameter int SHIFT_LENGTH = lbsd_pkg::SHIFT_LENGTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SHIFT_LENGTH-1:0] i_pattern,
    output logic                    o_active,
    output logic                    o_strobe,
    output logic                    o_serial_bit,
    output logic                    o_latch_pulse,
    output logic                    o_last_of_refresh
);

    localparam int PW = $clog2(SHIFT_LENGTH + 1);
    localparam logic [PW-1:0] POS_LATCH = PW'(SHIFT_LENGTH);

    logic                    r_active, n_active;
    logic                    r_phase, n_phase;
    logic [PW-1:0]           r_pos, n_pos;
    logic [SHIFT_LENGTH-1:0] r_sh, n_sh;
    logic                    r_strobe, n_strobe;
    logic                    r_bit, n_bit;
    logic                    r_latch, n_latch;
    logic                    r_last, n_last;

    // Emit one pulse a cycle: a zero run, a latch, the pattern run, a final latch
    always_comb begin
        n_active = r_active;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_sh     = r_sh;
        n_strobe = 1'b0;
        n_bit    = 1'b0;
        n_latch  = 1'b0;
        n_last   = 1'b0;
        if (r_active) begin
            n_strobe = 1'b1;
            if (r_pos == POS_LATCH) begin
                n_latch = 1'b1;
                n_last  = r_phase;
                n_pos   = '0;
                n_phase = 1'b1;
                if (r_phase) begin
                    n_active = 1'b0;
                end
            end else begin
                n_bit = r_phase & r_sh[0];
                n_pos = r_pos + PW'(1);
                if (r_phase) begin
                    n_sh = r_sh >> 1;
                end
            end
        end else if (i_start) begin
            n_active = 1'b1;
            n_phase  = 1'b0;
            n_pos    = '0;
            n_sh     = i_pattern;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= 1'b0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_strobe <= n_strobe;
        end
    end

    // Hold the payload of the current pulse
    always_ff @(posedge i_clk) begin
        r_sh    <= n_sh;
        r_bit   <= n_bit;
        r_latch <= n_latch;
        r_last  <= n_last;
    end

    assign o_active          = r_active;
    assign o_strobe          = r_strobe;
    assign o_serial_bit      = r_bit;
    assign o_latch_pulse     = r_latch;
    assign o_last_of_refresh = r_last;

endmodule

/* design/led_blink_serial_driver.sv */
// LED blink driver with a serial shift-register output. Commands are taken when
// start is high and busy is low. Tick and evaluate sweep the count and period
// memories one indicator a cycle (read, then write back in the next cycle);
// busy stays high until the last write-back. A set period is busy in ST_SET
// only, a clear not at all. A refresh emits 2 * (SHIFT_LENGTH + 1) results,
// one per cycle once the shifter's active and strobe flags are set, and holds
// busy until the shifter is idle. Each result is shown for one cycle under
// o_strobe and cannot be stalled; the receiver must take every strobed result.
module led_blink_serial_driver #(
    parameter int NUM_INDICATORS = lbsd_pkg::NUM_INDICATORS_DEF,
    parameter int SHIFT_LENGTH   = lbsd_pkg::SHIFT_LENGTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [lbsd_pkg::ACTION_W-1:0]      i_action,
    input  logic [lbsd_pkg::INDICATOR_W-1:0]   i_indicator,
    input  logic [lbsd_pkg::RATIO_W-1:0]       i_ratio,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lbsd_pkg::COUNT_W-1:0]       i_cfg_data,
    output logic                               o_strobe,
    output logic                               o_serial_bit,
    output logic                               o_latch_pulse,
    output logic                               o_last_of_refresh
);

    localparam int AW = lbsd_pkg::addr_w(NUM_INDICATORS);
    localparam int IW = $clog2(NUM_INDICATORS + 1);
    localparam int CW = lbsd_pkg::COUNT_W;
    localparam int PRW = lbsd_pkg::PRODUCT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_SET   = 4'b0100,
        ST_SHIFT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                      accept;
    logic [CW-1:0]             r_full_scale;
    logic                      r_eval;
    logic [AW-1:0]             r_set_addr;
    logic [lbsd_pkg::RATIO_W-1:0] r_set_ratio;
    logic [IW-1:0]             r_idx;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      r_pvld;
    logic [AW-1:0]             r_pidx;
    logic                      r_cnt_rv, r_per_rv;
    logic [NUM_INDICATORS-1:0] r_cnt_vld, r_per_vld;
    logic [NUM_INDICATORS-1:0] r_led;
    logic [CW-1:0]             cnt_rdata, per_rdata;
    logic [CW-1:0]             cnt_q, per_q;
    logic                      hit;
    logic                      cnt_we;
    logic [CW-1:0]             cnt_wdata;
    logic                      per_we;
    logic [PRW-1:0]            product;
    logic [CW-1:0]             per_wdata;
    logic                      set_ok;
    logic                      sh_start;
    logic                      sh_active;
    logic [SHIFT_LENGTH-1:0]   pattern;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Range checks for a set period command
    assign set_ok = (i_indicator < lbsd_pkg::INDICATOR_W'(NUM_INDICATORS))
                 && (i_ratio <= lbsd_pkg::RATIO_ONE);

    // Full-scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= lbsd_pkg::FULL_SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_full_scale <= i_cfg_data;
        end
    end

    // Decode the command and step the sequencer
    always_comb begin
        n_state  = r_state;
        sh_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        lbsd_pkg::ACT_TICK,
                        lbsd_pkg::ACT_EVAL:    n_state = ST_SWEEP;
                        lbsd_pkg::ACT_SET: begin
                            if (set_ok) begin
                                n_state = ST_SET;
                            end
                        end
                        lbsd_pkg::ACT_REFRESH: begin
                            n_state  = ST_SHIFT;
                            sh_start = 1'b1;
                        end
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (r_pvld && r_pidx == AW'(NUM_INDICATORS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SET:   n_state = ST_IDLE;
            ST_SHIFT: begin
                if (!sh_active) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sweep read side: one entry a cycle
    assign rd_en   = (r_state == ST_SWEEP) && (r_idx < IW'(NUM_INDICATORS));
    assign rd_addr = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_pvld    <= 1'b0;
            r_cnt_vld <= '0;
            r_per_vld <= '0;
            r_led     <= '0;
        end else begin
            r_state <= n_state;
            r_pvld  <= rd_en;
            if (accept) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + IW'(1);
            end
            if (cnt_we) begin
                r_cnt_vld[r_pidx] <= 1'b1;
            end
            if (per_we) begin
                r_per_vld[r_set_addr] <= 1'b1;
            end
            // Clear all states, or toggle on an evaluate hit
            if (accept && i_action == lbsd_pkg::ACT_CLEAR) begin
                r_led <= '0;
            end else if (r_pvld && r_eval && hit) begin
                r_led[r_pidx] <= ~r_led[r_pidx];
            end
        end
    end

    // Capture command operands and the read-side pipeline tags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_eval      <= (i_action == lbsd_pkg::ACT_EVAL);
            r_set_addr  <= i_indicator[AW-1:0];
            r_set_ratio <= i_ratio;
        end
        if (rd_en) begin
            r_pidx   <= rd_addr;
            r_cnt_rv <= r_cnt_vld[rd_addr];
            r_per_rv <= r_per_vld[rd_addr];
        end
    end

    // Write-back side: entries never written read as zero
    always_comb begin
        cnt_q = r_cnt_rv ? cnt_rdata : '0;
        per_q = r_per_rv ? per_rdata : '0;
        hit   = (per_q != '0) && (cnt_q >= per_q);
        if (r_eval) begin
            cnt_we    = r_pvld && hit;
            cnt_wdata = '0;
        end else begin
            cnt_we    = r_pvld;
            cnt_wdata = (cnt_q == lbsd_pkg::COUNT_MAX) ? cnt_q : cnt_q + CW'(1);
        end
    end

    // Period = floor(full_scale * ratio / 1024)
    assign product   = PRW'(r_full_scale) * PRW'(r_set_ratio);
    assign per_wdata = product[CW+9:10];
    assign per_we    = (r_state == ST_SET);

    lbsd_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_INDICATORS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_pidx),
        .i_wdata (cnt_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    lbsd_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_INDICATORS)
    ) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (r_set_addr),
        .i_wdata (per_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (per_rdata)
    );

    // Display pattern: bits beyond the indicators are zero
    for (genvar k = 0; k < SHIFT_LENGTH; k++) begin : g_pat
        if (k < NUM_INDICATORS) begin : g_led
            assign pattern[k] = r_led[k];
        end else begin : g_zero
            assign pattern[k] = 1'b0;
        end
    end

    lbsd_shift_out #(
        .SHIFT_LENGTH (SHIFT_LENGTH)
    ) u_shift_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (sh_start),
        .i_pattern         (pattern),
        .o_active          (sh_active),
        .o_strobe          (o_strobe),
        .o_serial_bit      (o_serial_bit),
        .o_latch_pulse     (o_latch_pulse),
        .o_last_of_refresh (o_last_of_refresh)
    );

endmodule

/* design/lbsd_checker.sv */
module lbsd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [lbsd_pkg::ACTION_W-1:0]    i_action,
    input logic                             o_strobe,
    input logic                             o_serial_bit,
    input logic                             o_latch_pulse,
    input logic                             o_last_of_refresh
);

    // Results only appear while a refresh holds the block
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result shown while not busy");

    // The final item of a refresh is a latch strobe
    a_last_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_of_refresh) |-> o_latch_pulse)
        else $error("last_of_refresh on a shift pulse");

    // Latch strobes carry a zero data bit
    a_latch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_latch_pulse) |-> !o_serial_bit)
        else $error("latch pulse with data bit set");

    // Nothing follows the final latch
    a_end_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_of_refresh) |=> !o_strobe)
        else $error("result after end of refresh");

    // A refresh transfer starts the pulse train via the shifter's active and strobe registers
    a_refresh_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == lbsd_pkg::ACT_REFRESH) |-> ##2 o_strobe)
        else $error("refresh did not start output");

endmodule

bind led_blink_serial_driver lbsd_checker u_lbsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_action          (i_action),
    .o_strobe          (o_strobe),
    .o_serial_bit      (o_serial_bit),
    .o_latch_pulse     (o_latch_pulse),
    .o_last_of_refresh (o_last_of_refresh)
);
